// File: rtl/mi_pkg.sv
// shared types, constants and cofactor schedule decode for the 4x4 matrix inverter
package mi_pkg;

    localparam int IDX_W     = 4;
    localparam int N_ELEM    = 16;
    localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;
    localparam logic [3:0] STEP_COF_END = 4'd8;
    localparam logic [3:0] STEP_DET     = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH_A,
        ST_FETCH_B,
        ST_LOAD_E,
        ST_MUL,
        ST_COF,
        ST_DCHK,
        ST_DREAD,
        ST_DLOAD,
        ST_DRUN,
        ST_DOUT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        X_ELEM,
        X_M,
        X_T
    } t_xsel;

    typedef enum logic [1:0] {
        TG_M,
        TG_T,
        TG_D
    } t_tgt;

    typedef struct packed {
        t_xsel            xsel;
        t_tgt             tgt;
        logic             clr;
        logic             sub;
        logic [IDX_W-1:0] addr_a;
        logic [IDX_W-1:0] addr_b;
    } t_op;

    // index into {0..3} with one value left out
    function automatic logic [1:0] pick(input logic [1:0] skip, input logic [1:0] i);
        logic [1:0] r;
        r = (i < skip) ? i : i + 2'd1;
        return r;
    endfunction

    // multiply-accumulate op for step s of cofactor k (adjugate position k)
    function automatic t_op op_decode(input logic [3:0] k, input logic [3:0] s);
        t_op        op;
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] g;
        logic [1:0] sub;
        logic [1:0] ca;
        logic [1:0] cb;
        r   = k[3:2];
        c   = k[1:0];
        g   = 2'd0;
        sub = 2'd0;
        case (s)
            4'd0: begin g = 2'd0; sub = 2'd0; end
            4'd1: begin g = 2'd0; sub = 2'd1; end
            4'd2: begin g = 2'd0; sub = 2'd2; end
            4'd3: begin g = 2'd1; sub = 2'd0; end
            4'd4: begin g = 2'd1; sub = 2'd1; end
            4'd5: begin g = 2'd1; sub = 2'd2; end
            4'd6: begin g = 2'd2; sub = 2'd0; end
            4'd7: begin g = 2'd2; sub = 2'd1; end
            4'd8: begin g = 2'd2; sub = 2'd2; end
            default: begin g = 2'd0; sub = 2'd3; end
        endcase
        case (g)
            2'd0:    begin ca = 2'd1; cb = 2'd2; end
            2'd1:    begin ca = 2'd0; cb = 2'd2; end
            default: begin ca = 2'd0; cb = 2'd1; end
        endcase
        op.addr_a = '0;
        op.addr_b = '0;
        case (sub)
            2'd0: begin
                // minor = e[1][a] * e[2][b]
                op.xsel   = X_ELEM;
                op.tgt    = TG_M;
                op.clr    = 1'b1;
                op.sub    = 1'b0;
                op.addr_a = {pick(c, 2'd1), pick(r, ca)};
                op.addr_b = {pick(c, 2'd2), pick(r, cb)};
            end
            2'd1: begin
                op.xsel   = X_ELEM;
                op.tgt    = TG_M;
                op.clr    = 1'b0;
                op.sub    = 1'b1;
                op.addr_a = {pick(c, 2'd1), pick(r, cb)};
                op.addr_b = {pick(c, 2'd2), pick(r, ca)};
            end
            2'd2: begin
                // expansion along row 0 of the 3x3 minor
                op.xsel   = X_M;
                op.tgt    = TG_T;
                op.clr    = (g == 2'd0);
                op.sub    = (g == 2'd1);
                op.addr_b = {pick(c, 2'd0), pick(r, g)};
            end
            default: begin
                // determinant term from the first column
                op.xsel   = X_T;
                op.tgt    = TG_D;
                op.clr    = (k == 4'd0);
                op.sub    = 1'b0;
                op.addr_b = {k[1:0], 2'b00};
            end
        endcase
        return op;
    endfunction

endpackage

// File: rtl/mi_elem_if.sv
// element load channel: valid, ready and one matrix element word
interface mi_elem_if #(
    parameter int ELEMENT_WIDTH = 32
);
    logic                                valid;
    logic                                ready;
    logic [mi_pkg::IDX_W-1:0]            element_index;
    logic signed [ELEMENT_WIDTH-1:0]     element_value;

    modport source (output valid, output element_index, output element_value, input ready);
    modport sink   (input valid, input element_index, input element_value, output ready);
endinterface

// File: rtl/mi_res_if.sv
// result channel: valid, ready and one inverse element word with flags
interface mi_res_if #(
    parameter int ELEMENT_WIDTH = 32
);
    logic                                valid;
    logic                                ready;
    logic [mi_pkg::IDX_W-1:0]            result_index;
    logic signed [ELEMENT_WIDTH-1:0]     result_value;
    logic                                singular;
    logic                                saturated;
    logic                                last_result;

    modport source (output valid, output result_index, output result_value,
                    output singular, output saturated, output last_result, input ready);
    modport sink   (input valid, input result_index, input result_value,
                    input singular, input saturated, input last_result, output ready);
endinterface

// File: rtl/mi_ram.sv
// generic single write port ram with registered read
module mi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/matrix_inverse_4x4.sv
// 4x4 fixed-point matrix inverse by adjugate over a shared shift-add unit and a restoring divider.
// Elements are loaded one word at a time at their row-major position.
// Loading position 15 starts an inversion of the stored matrix, during which no load is taken:
// 148 multiply-accumulate ops (nine per cofactor, four for the determinant) run one by one on the
// single add/subtract unit, with a cofactor write after each cofactor; then each of the 16
// results runs through the one-bit-per-cycle divider and waits out any output stall.
// The default parameters give Q16.16 elements. A zero determinant gives one result marked
// singular instead of 16.
module matrix_inverse_4x4 #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mi_elem_if.sink      i_elem,
    mi_res_if.source     o_res
);
    localparam int EW = ELEMENT_WIDTH;
    localparam int AW = 4 * EW + 4;
    localparam int DW = AW + 1;
    localparam int NW = AW + 2 * FRACTION_BITS + 2;
    localparam int CW = $clog2(NW);
    localparam int FS = 2 * FRACTION_BITS + 1;

    mi_pkg::t_state r_state, n_state;
    logic [3:0]     r_k;
    logic [3:0]     r_s;
    logic [CW-1:0]  r_cnt;
    mi_pkg::t_op    op;

    logic signed [AW-1:0] r_x, r_m, r_t, r_d;
    logic [EW-1:0]        r_e;
    logic [NW-1:0]        r_num;
    logic [DW-1:0]        r_rem;
    logic [EW-1:0]        r_q;
    logic                 r_ovf;
    logic                 r_neg;

    logic [mi_pkg::IDX_W-1:0] r_o_index;
    logic [EW-1:0]            r_o_value;
    logic                     r_o_sing;
    logic                     r_o_sat;
    logic                     r_o_last;

    logic                     in_ready;
    logic                     in_acc;
    logic [mi_pkg::IDX_W-1:0] elem_raddr;
    logic [EW-1:0]            elem_rdata;
    logic                     cof_we;
    logic [AW-1:0]            cof_rdata;

    logic                 mul_last;
    logic                 esub;
    logic signed [AW-1:0] tgt_cur;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] tgt_sum;
    logic signed [AW-1:0] cof_val;
    logic [AW-1:0]        abs_d;
    logic [DW-1:0]        den;
    logic [DW:0]          rem_sh;
    logic                 ge;
    logic                 div_last;
    logic                 cneg;
    logic [AW-1:0]        cmag;
    logic [EW-1:0]        lim;
    logic                 sat;
    logic [EW-1:0]        mag_o;

    assign op = mi_pkg::op_decode(r_k, r_s);

    mi_ram #(.WIDTH(EW), .DEPTH(mi_pkg::N_ELEM)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (i_elem.element_index),
        .i_wdata (i_elem.element_value),
        .i_raddr (elem_raddr),
        .o_rdata (elem_rdata)
    );

    mi_ram #(.WIDTH(AW), .DEPTH(mi_pkg::N_ELEM)) u_cof_ram (
        .i_clk   (i_clk),
        .i_we    (cof_we),
        .i_waddr (r_k),
        .i_wdata (cof_val),
        .i_raddr (r_k),
        .o_rdata (cof_rdata)
    );

    // shared shift-add unit: msb of the multiplier carries negative weight
    assign mul_last = (r_cnt == CW'(EW - 1));
    assign esub     = op.sub ^ mul_last;
    always_comb begin
        case (op.tgt)
            mi_pkg::TG_M: tgt_cur = r_m;
            mi_pkg::TG_T: tgt_cur = r_t;
            default:      tgt_cur = r_d;
        endcase
    end
    assign addend  = r_e[0] ? (esub ? -r_x : r_x) : '0;
    assign tgt_sum = tgt_cur + addend;
    assign cof_val = (r_k[2] ^ r_k[0]) ? -r_t : r_t;

    // divider
    assign abs_d    = r_d[AW-1] ? AW'(-r_d) : AW'(r_d);
    assign den      = {abs_d, 1'b0};
    assign rem_sh   = {r_rem, r_num[NW-1]};
    assign ge       = (rem_sh >= {1'b0, den});
    assign div_last = (r_cnt == CW'(NW - 1));
    assign cneg     = cof_rdata[AW-1];
    assign cmag     = cneg ? AW'(-cof_rdata) : cof_rdata;
    assign lim      = r_neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    assign sat      = r_ovf || (r_q > lim);
    assign mag_o    = sat ? lim : r_q;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mi_pkg::ST_IDLE: begin
                if (in_acc && i_elem.element_index == mi_pkg::LAST_IDX) begin
                    n_state = mi_pkg::ST_FETCH_A;
                end
            end
            mi_pkg::ST_FETCH_A: n_state = mi_pkg::ST_FETCH_B;
            mi_pkg::ST_FETCH_B: n_state = mi_pkg::ST_LOAD_E;
            mi_pkg::ST_LOAD_E:  n_state = mi_pkg::ST_MUL;
            mi_pkg::ST_MUL: begin
                if (mul_last) begin
                    n_state = (r_s == mi_pkg::STEP_COF_END) ? mi_pkg::ST_COF
                                                            : mi_pkg::ST_FETCH_A;
                end
            end
            mi_pkg::ST_COF: begin
                if (r_k[3:2] == 2'd0) begin
                    n_state = mi_pkg::ST_FETCH_A;
                end else if (r_k == mi_pkg::LAST_IDX) begin
                    n_state = mi_pkg::ST_DCHK;
                end else begin
                    n_state = mi_pkg::ST_FETCH_A;
                end
            end
            mi_pkg::ST_DCHK:  n_state = (r_d == '0) ? mi_pkg::ST_OUT : mi_pkg::ST_DREAD;
            mi_pkg::ST_DREAD: n_state = mi_pkg::ST_DLOAD;
            mi_pkg::ST_DLOAD: n_state = mi_pkg::ST_DRUN;
            mi_pkg::ST_DRUN: begin
                if (div_last) begin
                    n_state = mi_pkg::ST_DOUT;
                end
            end
            mi_pkg::ST_DOUT: n_state = mi_pkg::ST_OUT;
            mi_pkg::ST_OUT: begin
                if (o_res.ready) begin
                    n_state = r_o_last ? mi_pkg::ST_IDLE : mi_pkg::ST_DREAD;
                end
            end
            default: n_state = mi_pkg::ST_IDLE;
        endcase
    end

    // outputs of the control
    always_comb begin
        in_ready   = 1'b0;
        cof_we     = 1'b0;
        elem_raddr = op.addr_b;
        unique case (r_state)
            mi_pkg::ST_IDLE:    in_ready   = 1'b1;
            mi_pkg::ST_FETCH_A: elem_raddr = op.addr_a;
            mi_pkg::ST_COF:     cof_we     = 1'b1;
            default: ;
        endcase
    end

    assign in_acc         = i_elem.valid && in_ready;
    assign i_elem.ready   = in_ready;
    assign o_res.valid        = (r_state == mi_pkg::ST_OUT);
    assign o_res.result_index = r_o_index;
    assign o_res.result_value = r_o_value;
    assign o_res.singular     = r_o_sing;
    assign o_res.saturated    = r_o_sat;
    assign o_res.last_result  = r_o_last;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mi_pkg::ST_IDLE;
            r_k     <= '0;
            r_s     <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                mi_pkg::ST_IDLE: begin
                    r_k <= '0;
                    r_s <= '0;
                end
                mi_pkg::ST_LOAD_E: r_cnt <= '0;
                mi_pkg::ST_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (mul_last) begin
                        if (r_s == mi_pkg::STEP_DET) begin
                            r_k <= r_k + 1'b1;
                            r_s <= '0;
                        end else if (r_s != mi_pkg::STEP_COF_END) begin
                            r_s <= r_s + 1'b1;
                        end
                    end
                end
                mi_pkg::ST_COF: begin
                    if (r_k[3:2] == 2'd0) begin
                        r_s <= mi_pkg::STEP_DET;
                    end else if (r_k != mi_pkg::LAST_IDX) begin
                        r_k <= r_k + 1'b1;
                        r_s <= '0;
                    end
                end
                mi_pkg::ST_DCHK: r_k <= '0;
                mi_pkg::ST_DLOAD: r_cnt <= '0;
                mi_pkg::ST_DRUN: r_cnt <= r_cnt + 1'b1;
                mi_pkg::ST_OUT: begin
                    if (o_res.ready && !r_o_last) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mi_pkg::ST_FETCH_B: begin
                case (op.xsel)
                    mi_pkg::X_ELEM: r_x <= {{(AW-EW){elem_rdata[EW-1]}}, elem_rdata};
                    mi_pkg::X_M:    r_x <= r_m;
                    default:        r_x <= r_t;
                endcase
            end
            mi_pkg::ST_LOAD_E: begin
                r_e <= elem_rdata;
                if (op.clr) begin
                    case (op.tgt)
                        mi_pkg::TG_M: r_m <= '0;
                        mi_pkg::TG_T: r_t <= '0;
                        default:      r_d <= '0;
                    endcase
                end
            end
            mi_pkg::ST_MUL: begin
                case (op.tgt)
                    mi_pkg::TG_M: r_m <= tgt_sum;
                    mi_pkg::TG_T: r_t <= tgt_sum;
                    default:      r_d <= tgt_sum;
                endcase
                r_x <= r_x <<< 1;
                r_e <= r_e >> 1;
            end
            mi_pkg::ST_COF: r_t <= cof_val;
            mi_pkg::ST_DCHK: begin
                r_o_index <= '0;
                r_o_value <= '0;
                r_o_sing  <= 1'b1;
                r_o_sat   <= 1'b0;
                r_o_last  <= 1'b1;
            end
            mi_pkg::ST_DLOAD: begin
                // rounding: (2|c| * 2^2f + |d|) / 2|d|
                r_num <= (NW'(cmag) << FS) + NW'(abs_d);
                r_neg <= (cmag != '0) && (cneg != r_d[AW-1]);
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
            end
            mi_pkg::ST_DRUN: begin
                r_rem <= ge ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
                r_q   <= {r_q[EW-2:0], ge};
                r_ovf <= r_ovf | r_q[EW-1];
                r_num <= r_num << 1;
            end
            mi_pkg::ST_DOUT: begin
                r_o_index <= r_k;
                r_o_value <= r_neg ? EW'(-mag_o) : mag_o;
                r_o_sing  <= 1'b0;
                r_o_sat   <= sat;
                r_o_last  <= (r_k == mi_pkg::LAST_IDX);
            end
            default: ;
        endcase
    end
endmodule

// File: rtl/mi_checker.sv
// port-level checks on the matrix inverter, bound to the top level
module mi_checker #(
    parameter int ELEMENT_WIDTH = 32
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [3:0]               i_res_index,
    input logic [ELEMENT_WIDTH-1:0] i_res_value,
    input logic                     i_singular,
    input logic                     i_last
);
    // no load is taken while a word waits on the output
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("load ready while a result is pending");

    a_singular_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_singular |-> i_last && i_res_index == 4'd0 && i_res_value == '0)
        else $error("singular word malformed");

    a_back_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last |=> i_in_ready)
        else $error("not ready after last result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_value)
            && $stable(i_res_index))
        else $error("stalled result changed");
endmodule

bind matrix_inverse_4x4 mi_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_mi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_elem.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_res_index (o_res.result_index),
    .i_res_value (o_res.result_value),
    .i_singular  (o_res.singular),
    .i_last      (o_res.last_result)
);
